### hw/rtl/serial_frame_receiver_assert.svh
// ----------------------------------------------------------------------------
// Serial frame receiver assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_RECEIVER_ASSERT_SVH
`define SERIAL_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// Serial frame receiver package
// Request types, status codes and frame format constants.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

    // Frame format.
    localparam int unsigned HEADER_BYTES = 5;
    localparam logic [7:0] SCRAMBLE_MARK = 8'h7A;
    localparam logic [7:0] ADDR_NIBBLE_MASK = 8'hF0;
    localparam logic [3:0] ADDR_NIBBLE_MAX = 4'd7;
    localparam logic [7:0] CMD_FIRST = 8'hA0;
    localparam logic [7:0] CMD_LAST = 8'hA4;
    localparam logic [7:0] POS_SCRAMBLE = 8'd2;
    localparam logic [7:0] POS_COMMAND = 8'd3;

    // Register reset values.
    localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd59;
    localparam logic [7:0] IDLE_TICK_LIMIT_RESET = 8'd4;

    // Register indexes.
    localparam logic [0:0] REG_MAX_PAYLOAD = 1'd0;
    localparam logic [0:0] REG_IDLE_TICK_LIMIT = 1'd1;

    // Request kinds.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Frame status codes.
    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_SUM = 3'd1;
    localparam logic [2:0] ST_SCR = 3'd2;
    localparam logic [2:0] ST_CMD = 3'd3;
    localparam logic [2:0] ST_TIMEOUT = 3'd4;

    // Input request.
    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } in_item_t;

    // Result request.
    typedef struct packed {
        logic [7:0] frame_byte;
        logic [7:0] byte_position;
        logic       frame_end;
        logic [2:0] frame_status;
    } out_item_t;

    // Engine outputs for one processed request.
    typedef struct packed {
        logic      emit;
        logic      idle;
        out_item_t item;
    } step_result_t;

endpackage

`default_nettype wire

### hw/rtl/sfr_engine.sv
// ----------------------------------------------------------------------------
// Serial frame receiver engine
// Frame state registers and the single-pass update for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_engine (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire sfr_pkg::in_item_t     item,
    input  wire logic [7:0]            max_payload,
    input  wire logic [7:0]            idle_tick_limit,
    output sfr_pkg::step_result_t      result
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] byte_count_reg, byte_count_next;
    logic [7:0] frame_length_reg, frame_length_next;
    logic [7:0] running_sum_reg, running_sum_next;
    logic [7:0] idle_ticks_reg, idle_ticks_next;
    logic       scramble_ok_reg, scramble_ok_next;
    logic [7:0] command_byte_reg, command_byte_next;

    logic [8:0] tick_sum;
    logic [8:0] len_total;
    logic [8:0] last_pos;
    logic       scr_eff;
    logic [7:0] cmd_eff;
    logic [3:0] nibble;
    logic [7:0] b;

    assign b         = item.rx_byte;
    assign tick_sum  = {1'b0, idle_ticks_reg} + 9'd1;
    assign len_total = {1'b0, b} + 9'(sfr_pkg::HEADER_BYTES);
    assign last_pos  = {1'b0, frame_length_reg} + 9'(sfr_pkg::HEADER_BYTES - 1);
    assign nibble    = 4'((b & sfr_pkg::ADDR_NIBBLE_MASK) >> 4);
    assign scr_eff   = (byte_count_reg == sfr_pkg::POS_SCRAMBLE) ?
                       (b == sfr_pkg::SCRAMBLE_MARK) : scramble_ok_reg;
    assign cmd_eff   = (byte_count_reg == sfr_pkg::POS_COMMAND) ? b : command_byte_reg;

    // Next state and result for the request in the input register.
    always_comb
    begin
        phase_next        = phase_reg;
        byte_count_next   = byte_count_reg;
        frame_length_next = frame_length_reg;
        running_sum_next  = running_sum_reg;
        idle_ticks_next   = idle_ticks_reg;
        scramble_ok_next  = scramble_ok_reg;
        command_byte_next = command_byte_reg;
        result            = '0;
        result.idle       = (phase_reg != PH_LEN) && (phase_reg != PH_BODY);

        if (item.cmd == sfr_pkg::KIND_TICK)
        begin
            // Ticks only count while a frame is open.
            if (phase_reg == PH_LEN || phase_reg == PH_BODY)
            begin
                if (tick_sum > {1'b0, idle_tick_limit})
                begin
                    result.emit                    = 1'b1;
                    result.item.frame_byte         = 8'd0;
                    result.item.byte_position      = byte_count_reg;
                    result.item.frame_end          = 1'b1;
                    result.item.frame_status       = sfr_pkg::ST_TIMEOUT;
                    phase_next        = PH_IDLE;
                    byte_count_next   = 8'd0;
                    frame_length_next = 8'd0;
                    running_sum_next  = 8'd0;
                    idle_ticks_next   = 8'd0;
                    scramble_ok_next  = 1'b0;
                    command_byte_next = 8'd0;
                end
                else
                begin
                    idle_ticks_next = tick_sum[7:0];
                end
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_LEN:
                begin
                    if (b > max_payload || len_total > 9'd256)
                    begin
                        // Oversized length: drop the frame silently.
                        phase_next        = PH_IDLE;
                        byte_count_next   = 8'd0;
                        frame_length_next = 8'd0;
                        running_sum_next  = 8'd0;
                        idle_ticks_next   = 8'd0;
                        scramble_ok_next  = 1'b0;
                        command_byte_next = 8'd0;
                    end
                    else
                    begin
                        frame_length_next = b;
                        running_sum_next  = running_sum_reg + b;
                        byte_count_next   = 8'd2;
                        idle_ticks_next   = 8'd0;
                        phase_next        = PH_BODY;
                        result.emit               = 1'b1;
                        result.item.frame_byte    = b;
                        result.item.byte_position = 8'd1;
                        result.item.frame_status  = sfr_pkg::ST_OK;
                    end
                end
                PH_BODY:
                begin
                    result.emit               = 1'b1;
                    result.item.frame_byte    = b;
                    result.item.byte_position = byte_count_reg;
                    scramble_ok_next          = scr_eff;
                    command_byte_next         = cmd_eff;
                    if ({1'b0, byte_count_reg} >= last_pos)
                    begin
                        // Checksum byte: verdict in priority order.
                        result.item.frame_end = 1'b1;
                        if (running_sum_reg != b)
                            result.item.frame_status = sfr_pkg::ST_SUM;
                        else if (!scr_eff)
                            result.item.frame_status = sfr_pkg::ST_SCR;
                        else if (cmd_eff < sfr_pkg::CMD_FIRST || cmd_eff > sfr_pkg::CMD_LAST)
                            result.item.frame_status = sfr_pkg::ST_CMD;
                        else
                            result.item.frame_status = sfr_pkg::ST_OK;
                        phase_next        = PH_IDLE;
                        byte_count_next   = 8'd0;
                        frame_length_next = 8'd0;
                        running_sum_next  = 8'd0;
                        idle_ticks_next   = 8'd0;
                        scramble_ok_next  = 1'b0;
                        command_byte_next = 8'd0;
                    end
                    else
                    begin
                        running_sum_next = running_sum_reg + b;
                        byte_count_next  = byte_count_reg + 8'd1;
                        idle_ticks_next  = 8'd0;
                    end
                end
                default:
                begin
                    // Idle, and the unused phase code: look for an address.
                    phase_next        = PH_IDLE;
                    byte_count_next   = 8'd0;
                    frame_length_next = 8'd0;
                    running_sum_next  = 8'd0;
                    idle_ticks_next   = 8'd0;
                    scramble_ok_next  = 1'b0;
                    command_byte_next = 8'd0;
                    if (nibble != 4'd0 && nibble <= sfr_pkg::ADDR_NIBBLE_MAX)
                    begin
                        running_sum_next          = b;
                        byte_count_next           = 8'd1;
                        phase_next                = PH_LEN;
                        result.emit               = 1'b1;
                        result.item.frame_byte    = b;
                        result.item.byte_position = 8'd0;
                        result.item.frame_status  = sfr_pkg::ST_OK;
                    end
                end
            endcase
        end
    end

    // Frame state, updated once per processed request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            byte_count_reg   <= 8'd0;
            frame_length_reg <= 8'd0;
            running_sum_reg  <= 8'd0;
            idle_ticks_reg   <= 8'd0;
            scramble_ok_reg  <= 1'b0;
            command_byte_reg <= 8'd0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            byte_count_reg   <= byte_count_next;
            frame_length_reg <= frame_length_next;
            running_sum_reg  <= running_sum_next;
            idle_ticks_reg   <= idle_ticks_next;
            scramble_ok_reg  <= scramble_ok_next;
            command_byte_reg <= command_byte_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/serial_frame_receiver.sv
// ----------------------------------------------------------------------------
// Serial frame receiver
// Length-prefixed frame receiver with an 8-bit additive checksum.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_ready, in_item) carries one request per
// received UART byte (cmd 0) or timer tick (cmd 1). The output channel
// (out_valid, out_ready, out_item) carries at most one result per request:
// each accepted frame byte with its position, and a verdict on the last byte
// or on a timeout abort. Requests that are filtered out give no result.
// A request sits in the input register while the frame state update computes
// its result, and the output register takes that result once the output slot
// is free. Throughput is one request per cycle while the output is not
// stalled; the frame state update is a single pass per request. When
// out_ready is low with a result waiting, one more request is held in the
// input register and in_ready then drops.
// Reset clears the frame state, empties both registers and loads
// max_payload with 59 and idle_tick_limit with 4. The cfg_we port writes
// these registers; use it only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_frame_receiver (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire sfr_pkg::in_item_t   in_item,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output sfr_pkg::out_item_t       out_item,
    input  wire logic                cfg_we,
    input  wire logic [0:0]          cfg_index,
    input  wire logic [7:0]          cfg_data
);

    logic                  in_valid_reg;
    sfr_pkg::in_item_t     in_item_reg;
    logic                  out_valid_reg, out_valid_next;
    sfr_pkg::out_item_t    out_item_reg;
    logic [7:0]            max_payload_reg;
    logic [7:0]            idle_tick_limit_reg;
    logic                  step;
    sfr_pkg::step_result_t result;

    // The held request is processed when the output slot is free.
    assign step     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step;

    sfr_engine u_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .item            (in_item_reg),
        .max_payload     (max_payload_reg),
        .idle_tick_limit (idle_tick_limit_reg),
        .result          (result)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_item_reg <= in_item;
    end

    // Output register.
    always_comb
    begin
        if (step && result.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (step && result.emit)
            out_item_reg <= result.item;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg     <= sfr_pkg::MAX_PAYLOAD_RESET;
            idle_tick_limit_reg <= sfr_pkg::IDLE_TICK_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sfr_pkg::REG_MAX_PAYLOAD:     max_payload_reg     <= cfg_data;
                sfr_pkg::REG_IDLE_TICK_LIMIT: idle_tick_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Checks.
`include "serial_frame_receiver_assert.svh"

    `SFR_ASSERT_NOW(a_stall_only_on_full_output, clk, rst_n,
        in_valid_reg && !step, out_valid_reg && !out_ready,
        "input register held while the output slot was free")

    `SFR_ASSERT_NOW(a_timeout_result_shape, clk, rst_n,
        out_valid && out_item.frame_status == sfr_pkg::ST_TIMEOUT,
        out_item.frame_end && out_item.frame_byte == 8'd0,
        "timeout result without frame end or with a nonzero byte")

    `SFR_ASSERT_NOW(a_status_only_at_end, clk, rst_n,
        out_valid && !out_item.frame_end, out_item.frame_status == sfr_pkg::ST_OK,
        "error status reported before the end of a frame")

    `SFR_ASSERT_NEXT(a_idle_after_end, clk, rst_n,
        step && result.emit && result.item.frame_end, result.idle,
        "frame state not cleared after a frame end")

endmodule

`default_nettype wire

### test/serial_frame_receiver_tb.sv
// ----------------------------------------------------------------------------
// Serial frame receiver testbench
// Feeds serial bytes and timer ticks through the input channel and checks
// every result against a typed answer or a cycle-free frame state model.
// A short scripted sequence covers address filtering, all verdicts, the
// length limit and the tick timeout. Random frames then follow under
// several register settings and handshake idling patterns.
// ----------------------------------------------------------------------------

module serial_frame_receiver_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sfr_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 200;
    localparam int SCRIPT_ROWS = 31;

    typedef enum logic [1:0] {
        RX_IDLE   = 2'd0,
        RX_LENGTH = 2'd1,
        RX_BODY   = 2'd2
    } rx_phase_e;

    // One row of the scripted sequence. A row with a typed answer is checked
    // against that answer; any other row is checked against the frame model.
    typedef struct {
        in_item_t  req;
        bit        typed;
        bit        want_res;
        out_item_t want;
    } script_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    in_item_t   in_item = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_item_t  out_item;
    logic       cfg_we = 1'b0;
    logic [0:0] cfg_index = REG_MAX_PAYLOAD;
    logic [7:0] cfg_data = 8'h00;

    // Register shadows and frame state of the model.
    logic [7:0] max_payload = MAX_PAYLOAD_RESET;
    logic [7:0] tick_limit = IDLE_TICK_LIMIT_RESET;
    rx_phase_e  rx_phase = RX_IDLE;
    logic [7:0] rx_count = 8'h00;
    logic [7:0] rx_length = 8'h00;
    logic [7:0] rx_sum = 8'h00;
    logic [7:0] rx_ticks = 8'h00;
    logic       rx_scramble_ok = 1'b0;
    logic [7:0] rx_command = 8'h00;

    out_item_t   expected_results [$];
    script_row_t script [SCRIPT_ROWS];

    int          failures = 0;
    int          items_done = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int unsigned cycle_count = 0;
    int          hold_left = 0;
    bit          hold_token = 1'b0;
    bit          hold_seen = 1'b0;

    serial_frame_receiver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run time guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Compare each accepted result with the oldest pending prediction.
    always @(posedge clk)
    begin : check_results
        out_item_t due;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: byte %0h position %0d end %0b status %0d",
                       out_item.frame_byte, out_item.byte_position,
                       out_item.frame_end, out_item.frame_status);
                failures++;
            end
            else
            begin
                due = expected_results.pop_front();
                if (out_item.frame_byte !== due.frame_byte)
                begin
                    $error("frame_byte: expected %0h, got %0h",
                           due.frame_byte, out_item.frame_byte);
                    failures++;
                end
                if (out_item.byte_position !== due.byte_position)
                begin
                    $error("byte_position: expected %0d, got %0d",
                           due.byte_position, out_item.byte_position);
                    failures++;
                end
                if (out_item.frame_end !== due.frame_end)
                begin
                    $error("frame_end: expected %0b, got %0b",
                           due.frame_end, out_item.frame_end);
                    failures++;
                end
                if (out_item.frame_status !== due.frame_status)
                begin
                    $error("frame_status: expected %0d, got %0d",
                           due.frame_status, out_item.frame_status);
                    failures++;
                end
            end
        end
    end

    function automatic out_item_t make_result(logic [7:0] b, logic [7:0] pos,
                                              logic last, logic [2:0] st);
        out_item_t r;
        r.frame_byte = b;
        r.byte_position = pos;
        r.frame_end = last;
        r.frame_status = st;
        return r;
    endfunction

    function automatic script_row_t row(logic kind, logic [7:0] b, bit typed,
                                        bit want_res, logic [7:0] fb,
                                        logic [7:0] pos, logic last,
                                        logic [2:0] st);
        script_row_t r;
        r.req.cmd = kind;
        r.req.rx_byte = b;
        r.typed = typed;
        r.want_res = want_res;
        r.want = make_result(fb, pos, last, st);
        return r;
    endfunction

    function automatic void clear_frame();
        rx_phase = RX_IDLE;
        rx_count = 8'h00;
        rx_length = 8'h00;
        rx_sum = 8'h00;
        rx_ticks = 8'h00;
        rx_scramble_ok = 1'b0;
        rx_command = 8'h00;
    endfunction

    // Frame model: advance the state by one request and give its result.
    // The counted flag is low only for requests that the block ignores.
    task automatic advance_frame(input in_item_t req, output bit has_res,
                                 output out_item_t res, output bit counted);
        logic [7:0] b;
        logic [7:0] pos;
        logic [2:0] verdict;
        int         last_pos;
        b = req.rx_byte;
        has_res = 1'b0;
        res = '0;
        counted = (rx_phase == RX_LENGTH || rx_phase == RX_BODY);
        if (req.cmd == KIND_TICK)
        begin
            // Ticks only matter inside a frame; one past the limit aborts it.
            if (counted)
            begin
                if (int'(rx_ticks) + 1 > int'(tick_limit))
                begin
                    res = make_result(8'h00, rx_count, 1'b1, ST_TIMEOUT);
                    has_res = 1'b1;
                    clear_frame();
                end
                else
                begin
                    rx_ticks = rx_ticks + 8'd1;
                end
            end
        end
        else
        begin
            case (rx_phase)
                RX_LENGTH:
                begin
                    // Lengths above the limit, or too long for 8-bit positions,
                    // silently drop the frame.
                    if (b > max_payload || int'(b) + int'(HEADER_BYTES) > 256)
                    begin
                        clear_frame();
                    end
                    else
                    begin
                        rx_length = b;
                        rx_sum = rx_sum + b;
                        rx_count = 8'd2;
                        rx_ticks = 8'h00;
                        rx_phase = RX_BODY;
                        res = make_result(b, 8'd1, 1'b0, ST_OK);
                        has_res = 1'b1;
                    end
                end
                RX_BODY:
                begin
                    pos = rx_count;
                    last_pos = int'(rx_length) + int'(HEADER_BYTES) - 1;
                    if (pos == POS_SCRAMBLE)
                        rx_scramble_ok = (b == SCRAMBLE_MARK);
                    if (pos == POS_COMMAND)
                        rx_command = b;
                    if (int'(pos) >= last_pos)
                    begin
                        // Checksum beats scramble, scramble beats command.
                        if (rx_sum != b)
                            verdict = ST_SUM;
                        else if (!rx_scramble_ok)
                            verdict = ST_SCR;
                        else if (rx_command < CMD_FIRST || rx_command > CMD_LAST)
                            verdict = ST_CMD;
                        else
                            verdict = ST_OK;
                        clear_frame();
                        res = make_result(b, pos, 1'b1, verdict);
                    end
                    else
                    begin
                        rx_sum = rx_sum + b;
                        rx_count = pos + 8'd1;
                        rx_ticks = 8'h00;
                        res = make_result(b, pos, 1'b0, ST_OK);
                    end
                    has_res = 1'b1;
                end
                default:
                begin
                    // Idle: only an address with upper nibble 1 to 7 opens a frame.
                    clear_frame();
                    if (b[7:4] != 4'd0 && b[7:4] <= ADDR_NIBBLE_MAX)
                    begin
                        rx_sum = b;
                        rx_count = 8'd1;
                        rx_phase = RX_LENGTH;
                        res = make_result(b, 8'd0, 1'b0, ST_OK);
                        has_res = 1'b1;
                    end
                end
            endcase
        end
        counted = counted || has_res;
    endtask

    // Offer one request, wait for it to be taken and record its outcome.
    task automatic send_request(input in_item_t req, input bit typed,
                                input bit want_res, input out_item_t want);
        bit        has_res;
        bit        counted;
        out_item_t res;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= req;
        do
            @(posedge clk);
        while (!in_ready);
        advance_frame(req, has_res, res, counted);
        if (typed)
        begin
            if (want_res)
                expected_results.push_back(want);
        end
        else if (has_res)
        begin
            expected_results.push_back(res);
        end
        if (counted)
            items_done++;
    endtask

    task automatic send_predicted(input logic kind, input logic [7:0] b);
        in_item_t req;
        req.cmd = kind;
        req.rx_byte = b;
        send_request(req, 1'b0, 1'b0, '0);
    endtask

    // Enough ticks to pass the limit and abort the open frame.
    task automatic abort_by_ticks();
        repeat (int'(tick_limit) + 1)
            send_predicted(KIND_TICK, 8'($urandom_range(255)));
    endtask

    // Ticks between frame bytes: mostly none, sometimes up to three that stay
    // under the limit, now and then enough to abort.
    task automatic stall_ticks(output bit aborted);
        int r;
        r = $urandom_range(99);
        aborted = 1'b0;
        if (r < 2)
        begin
            abort_by_ticks();
            aborted = 1'b1;
        end
        else if (r < 10)
        begin
            repeat ($urandom_range(tick_limit < 8'd3 ? int'(tick_limit) : 3))
                send_predicted(KIND_TICK, 8'($urandom_range(255)));
        end
    endtask

    // One frame with random content, mostly well formed. A negative
    // length argument picks a random length.
    task automatic send_frame(input int force_len);
        logic [7:0] addr;
        logic [7:0] len;
        logic [7:0] sum;
        logic [7:0] val;
        int         lr;
        int         trunc_at;
        int         last_pos;
        bit         aborted;
        if (rx_phase != RX_IDLE)
            abort_by_ticks();
        addr = {4'($urandom_range(7, 1)), 4'($urandom_range(15))};
        lr = $urandom_range(99);
        if (force_len >= 0)
            len = 8'(force_len);
        else if (lr < 8)
            len = 8'($urandom_range(255, int'(max_payload) + 1));
        else if (lr < 12)
            len = max_payload;
        else
            len = 8'($urandom_range(max_payload < 8'd10 ? int'(max_payload) : 10));
        send_predicted(KIND_BYTE, addr);
        stall_ticks(aborted);
        if (aborted)
            return;
        send_predicted(KIND_BYTE, len);
        if (rx_phase == RX_IDLE)
            return;
        sum = addr + len;
        last_pos = int'(len) + int'(HEADER_BYTES) - 1;
        trunc_at = ($urandom_range(99) < 4) ? $urandom_range(last_pos, 2) : -1;
        for (int pos = 2; pos <= last_pos; pos++)
        begin
            stall_ticks(aborted);
            if (aborted || pos == trunc_at)
                return;
            if (pos == int'(POS_SCRAMBLE))
                val = ($urandom_range(99) < 85) ? SCRAMBLE_MARK : 8'($urandom_range(255));
            else if (pos == int'(POS_COMMAND))
                val = ($urandom_range(99) < 85) ? CMD_FIRST + 8'($urandom_range(4))
                                                : 8'($urandom_range(255));
            else if (pos == last_pos)
                val = ($urandom_range(99) < 85) ? sum : 8'($urandom_range(255));
            else
                val = 8'($urandom_range(255));
            send_predicted(KIND_BYTE, val);
            sum = sum + val;
        end
    endtask

    // Random traffic: mostly frames, the rest single noise requests.
    task automatic random_traffic(input int target);
        items_done = 0;
        while (items_done < target)
        begin
            if ($urandom_range(99) < 10)
                send_predicted(1'($urandom_range(1)), 8'($urandom_range(255)));
            else
                send_frame(-1);
        end
    endtask

    // Stop offering requests until every result is out and the pipeline
    // has had time to clear any request that gives none.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic set_limits(input logic [7:0] payload, input logic [7:0] ticks);
        cfg_we <= 1'b1;
        cfg_index <= REG_MAX_PAYLOAD;
        cfg_data <= payload;
        @(posedge clk);
        cfg_index <= REG_IDLE_TICK_LIMIT;
        cfg_data <= ticks;
        @(posedge clk);
        cfg_we <= 1'b0;
        max_payload = payload;
        tick_limit = ticks;
    endtask

    task automatic run_phase(input logic [7:0] payload, input logic [7:0] ticks,
                             input int send_idle, input int recv_stall,
                             input int target, input bit hold);
        drain_results();
        set_limits(payload, ticks);
        idle_pct = send_idle;
        stall_pct = recv_stall;
        if (hold)
            hold_token <= ~hold_token;
        random_traffic(target);
    endtask

    initial
    begin
        // Scripted sequence under the reset register values.
        script = '{
            // Ticks and bytes outside the address range are ignored in idle.
            row(KIND_TICK, 8'hFF, 1, 0, 8'h00, 8'd0, 1'b0, ST_OK),
            row(KIND_BYTE, 8'h05, 1, 0, 8'h00, 8'd0, 1'b0, ST_OK),
            row(KIND_BYTE, 8'h80, 1, 0, 8'h00, 8'd0, 1'b0, ST_OK),
            // Shortest good frame.
            row(KIND_BYTE, 8'h10, 1, 1, 8'h10, 8'd0, 1'b0, ST_OK),
            row(KIND_BYTE, 8'h00, 1, 1, 8'h00, 8'd1, 1'b0, ST_OK),
            row(KIND_BYTE, 8'h7A, 1, 1, 8'h7A, 8'd2, 1'b0, ST_OK),
            row(KIND_BYTE, 8'hA0, 1, 1, 8'hA0, 8'd3, 1'b0, ST_OK),
            row(KIND_BYTE, 8'h2A, 1, 1, 8'h2A, 8'd4, 1'b1, ST_OK),
            // Bad checksum.
            row(KIND_BYTE, 8'h7F, 0, 0, 8'h00, 8'd0, 1'b0, ST_OK),
            row(KIND_BYTE, 8'h00, 0, 0, 8'h00, 8'd0, 1'b0, ST_OK),
            row(KIND_BYTE, 8'h7A, 0, 0, 8'h00, 8'd0, 1'b0, ST_OK),
            row(KIND_BYTE, 8'hA4, 0, 0, 8'h00, 8'd0, 1'b0, ST_OK),
            row(KIND_BYTE, 8'hFF, 1, 1, 8'hFF, 8'd4, 1'b1, ST_SUM),
            // Bad scramble byte together with an unknown command.
            row(KIND_BYTE, 8'h20, 0, 0, 8'h00, 8'd0, 1'b0, ST_OK),
            row(KIND_BYTE, 8'h00, 0, 0, 8'h00, 8'd0, 1'b0, ST_OK),
            row(KIND_BYTE, 8'h7B, 0, 0, 8'h00, 8'd0, 1'b0, ST_OK),
            row(KIND_BYTE, 8'hA5, 0, 0, 8'h00, 8'd0, 1'b0, ST_OK),
            row(KIND_BYTE, 8'h40, 1, 1, 8'h40, 8'd4, 1'b1, ST_SCR),
            // Unknown command just below the valid range.
            row(KIND_BYTE, 8'h30, 0, 0, 8'h00, 8'd0, 1'b0, ST_OK),
            row(KIND_BYTE, 8'h00, 0, 0, 8'h00, 8'd0, 1'b0, ST_OK),
            row(KIND_BYTE, 8'h7A, 0, 0, 8'h00, 8'd0, 1'b0, ST_OK),
            row(KIND_BYTE, 8'h9F, 0, 0, 8'h00, 8'd0, 1'b0, ST_OK),
            row(KIND_BYTE, 8'h49, 1, 1, 8'h49, 8'd4, 1'b1, ST_CMD),
            // Length one above the limit drops the frame.
            row(KIND_BYTE, 8'h4F, 0, 0, 8'h00, 8'd0, 1'b0, ST_OK),
            row(KIND_BYTE, 8'h3C, 1, 0, 8'h00, 8'd0, 1'b0, ST_OK),
            // The fifth tick without a byte aborts the frame.
            row(KIND_BYTE, 8'h50, 0, 0, 8'h00, 8'd0, 1'b0, ST_OK),
            row(KIND_TICK, 8'h00, 0, 0, 8'h00, 8'd0, 1'b0, ST_OK),
            row(KIND_TICK, 8'hFF, 0, 0, 8'h00, 8'd0, 1'b0, ST_OK),
            row(KIND_TICK, 8'h00, 0, 0, 8'h00, 8'd0, 1'b0, ST_OK),
            row(KIND_TICK, 8'h55, 0, 0, 8'h00, 8'd0, 1'b0, ST_OK),
            row(KIND_TICK, 8'hAA, 1, 1, 8'h00, 8'd1, 1'b1, ST_TIMEOUT)
        };

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            send_request(script[i].req, script[i].typed, script[i].want_res,
                         script[i].want);

        // Random frames under the reset values, no idling.
        random_traffic(100);

        // Smallest limits, sender mostly idle.
        run_phase(8'd0, 8'd0, 60, 0, 100, 1'b0);

        // Payload limit 250 and the largest tick limit, receiver mostly stalled;
        // one frame at the payload limit and one abort on the 256th tick.
        run_phase(8'd250, 8'd255, 0, 60, 80, 1'b0);
        send_frame(250);
        send_predicted(KIND_BYTE, 8'h7E);
        abort_by_ticks();

        // Both sides idling.
        run_phase(8'd7, 8'd2, 21, 21, 150, 1'b0);

        // Long receiver hold-off while requests keep coming.
        run_phase(8'd59, 8'd1, 0, 0, 120, 1'b1);

        // Random limits with both sides idling.
        run_phase(8'($urandom_range(250)), 8'($urandom_range(8)), 21, 21, 150, 1'b0);

        drain_results();
        repeat (8)
            @(posedge clk);
        if (failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_engine.sv
hw/rtl/serial_frame_receiver.sv
test/serial_frame_receiver_tb.sv
